// ----- design/vdr_pkg.sv -----
// Shared types and constants of the vertex welding block.
// No dependencies; the interfaces, the distance pipeline and the top module use it.
`default_nettype none

package vdr_pkg;

   // Width of the weld threshold register
   localparam int EPS_W = 52;

   // Operation carried by a request
   typedef enum logic {
      CMD_ADD,
      CMD_LOOKUP
   } command_type;

   // Outcome reported with every response
   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_FULL,
      STATUS_UNLOADED
   } status_type;

endpackage

`default_nettype wire

// ----- design/vdr_if.sv -----
// Request and response channel interfaces of the vertex welding block.
// Depends on vdr_pkg for the command and status types.
`default_nettype none

interface vdr_req_if #(
   parameter int COORD_BITS = 24,
   parameter int IDX_W      = 10
);
   logic                    valid;
   logic                    ready;
   vdr_pkg::command_type    command;
   logic                    first_of_mesh;
   logic signed [COORD_BITS-1:0] coord_x;
   logic signed [COORD_BITS-1:0] coord_y;
   logic signed [COORD_BITS-1:0] coord_z;
   logic [IDX_W-1:0]        corner_index;

   modport source (
      output valid, command, first_of_mesh, coord_x, coord_y, coord_z, corner_index,
      input  ready
   );
   modport sink (
      input  valid, command, first_of_mesh, coord_x, coord_y, coord_z, corner_index,
      output ready
   );
endinterface

interface vdr_rsp_if #(
   parameter int IDX_W = 10
);
   logic                 valid;
   logic                 ready;
   logic [IDX_W-1:0]     unique_index;
   logic                 is_new;
   vdr_pkg::status_type  status;

   modport source (
      output valid, unique_index, is_new, status,
      input  ready
   );
   modport sink (
      input  valid, unique_index, is_new, status,
      output ready
   );
endinterface

`default_nettype wire

// ----- design/vdr_mem.sv -----
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// No package dependencies; used for the unique point store and the remap table.
`default_nettype none

module vdr_mem #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- design/vdr_dist.sv -----
// Three-stage squared-distance pipeline: axis differences, squares, sum and threshold compare.
// Depends on vdr_pkg for the threshold width.
`default_nettype none

module vdr_dist #(
   parameter int COORD_BITS = 24,
   parameter int IDX_W      = 10
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      flush,
   input  logic                      in_vld,
   input  logic [IDX_W-1:0]          in_tag,
   input  logic                      in_last,
   input  logic [3*COORD_BITS-1:0]   ref_pt,
   input  logic [3*COORD_BITS-1:0]   mem_pt,
   input  logic [vdr_pkg::EPS_W-1:0] eps,
   output logic                      out_vld,
   output logic                      out_hit,
   output logic [IDX_W-1:0]          out_tag,
   output logic                      out_last
);
   import vdr_pkg::*;

   localparam int DIFF_W = COORD_BITS + 1;
   localparam int SQ_W   = 2 * DIFF_W;
   localparam int SUM_W  = SQ_W + 2;
   localparam int CMP_W  = (SUM_W > EPS_W) ? SUM_W : EPS_W;

   logic signed [DIFF_W-1:0] diff_in [3];
   logic signed [DIFF_W-1:0] diff_ff [3];
   logic signed [SQ_W-1:0]   prod    [3];
   logic [SQ_W-1:0]          sq_ff   [3];
   logic [CMP_W-1:0]         sum;

   logic             vld_a_ff, vld_b_ff, vld_c_ff;
   logic [IDX_W-1:0] tag_a_ff, tag_b_ff, tag_c_ff;
   logic             last_a_ff, last_b_ff, last_c_ff;
   logic             hit_ff;

   // Per-axis differences, exact at one extra bit
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff_in[i] = $signed({ref_pt[i*COORD_BITS + COORD_BITS - 1],
                               ref_pt[i*COORD_BITS +: COORD_BITS]})
                    - $signed({mem_pt[i*COORD_BITS + COORD_BITS - 1],
                               mem_pt[i*COORD_BITS +: COORD_BITS]});
         prod[i]    = diff_ff[i] * diff_ff[i];
      end
   end

   // Sum of squares; the compare width holds the largest sum, so no saturation is needed
   assign sum = CMP_W'(sq_ff[0]) + CMP_W'(sq_ff[1]) + CMP_W'(sq_ff[2]);

   // Advance the payload through the stages
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         diff_ff[i] <= diff_in[i];
         sq_ff[i]   <= SQ_W'($unsigned(prod[i]));
      end
      tag_a_ff  <= in_tag;
      last_a_ff <= in_last;
      tag_b_ff  <= tag_a_ff;
      last_b_ff <= last_a_ff;
      tag_c_ff  <= tag_b_ff;
      last_c_ff <= last_b_ff;
      hit_ff    <= (sum < CMP_W'(eps));
   end

   // Stage valids; drop everything in flight on flush
   always_ff @(posedge clock) begin
      if (reset || flush) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
         vld_c_ff <= 1'b0;
      end else begin
         vld_a_ff <= in_vld;
         vld_b_ff <= vld_a_ff;
         vld_c_ff <= vld_b_ff;
      end
   end

   assign out_vld  = vld_c_ff;
   assign out_hit  = hit_ff;
   assign out_tag  = tag_c_ff;
   assign out_last = last_c_ff;

endmodule

`default_nettype wire

// ----- design/vertex_dedup_remap.sv -----
// Vertex welding block: merges mesh vertices closer than a threshold and keeps
// the map from original vertex index to unique index.
//
// Channels: req_chan takes one request per handshake (valid and ready high).
// An add request (command CMD_ADD) carries x, y and z; a lookup request
// (CMD_LOOKUP) carries corner_index. first_of_mesh empties both tables first.
// Every request gives exactly one response on rsp_chan: unique_index, is_new
// and status (ok, table full, index not loaded). The weld threshold is written
// through csr_wr_en and csr_wr_data; the user must do so with no request in flight (not enforced).
//
// Flow: an add against the stored unique points streams the point memory one
// entry per cycle through a three-stage distance pipeline and stops at the
// first entry that matches. An add into an empty table passes through commit
// and done; a loaded lookup through lookup and done; an add into a full table
// and a lookup of an unloaded index go straight to done. One request is worked
// on at a time; the point memory read port sets the rate.
// Reset empties both tables, clears the threshold and drops any response.
// A stalled response sits in the output register while the next request is
// accepted and worked on; that request waits to retire until the slot frees.
`default_nettype none

module vertex_dedup_remap #(
   parameter int MAX_VERTICES = 1024,
   parameter int COORD_BITS   = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   vdr_req_if.sink                   req_chan,
   vdr_rsp_if.source                 rsp_chan,
   input  logic                      csr_wr_en,
   input  logic [vdr_pkg::EPS_W-1:0] csr_wr_data
);
   import vdr_pkg::*;

   localparam int IDX_W = $clog2(MAX_VERTICES);
   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   localparam int PT_W  = 3 * COORD_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_LOOKUP,
      ST_COMMIT,
      ST_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] uniq_cnt_ff, uniq_cnt_in;
   logic [CNT_W-1:0] orig_cnt_ff, orig_cnt_in;
   logic [EPS_W-1:0] eps_ff, eps_in;
   logic [PT_W-1:0]  ref_pt_ff, ref_pt_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic             issue_done_ff, issue_done_in;
   logic             iss_vld_ff, iss_vld_in;
   logic [IDX_W-1:0] iss_tag_ff, iss_tag_in;
   logic             iss_last_ff, iss_last_in;
   logic [IDX_W-1:0] res_idx_ff, res_idx_in;
   logic             res_new_ff, res_new_in;
   status_type       res_status_ff, res_status_in;
   logic             rsp_vld_ff, rsp_vld_in;
   logic [IDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic             rsp_new_ff, rsp_new_in;
   status_type       rsp_status_ff, rsp_status_in;

   logic             accept;
   logic [CNT_W-1:0] uniq_eff, orig_eff;
   logic             pt_we, rm_we, flush;
   logic [PT_W-1:0]  pt_rdata;
   logic [IDX_W-1:0] rm_rdata;
   logic             dist_vld, dist_hit, dist_last;
   logic [IDX_W-1:0] dist_tag;

   // Unique point store, x in the low bits
   vdr_mem #(
      .WIDTH  (PT_W),
      .DEPTH  (MAX_VERTICES),
      .ADDR_W (IDX_W)
   ) u_point_mem (
      .clock   (clock),
      .wr_en   (pt_we),
      .wr_addr (res_idx_ff),
      .wr_data (ref_pt_ff),
      .rd_addr (rd_idx_ff),
      .rd_data (pt_rdata)
   );

   // Original index to unique index table
   vdr_mem #(
      .WIDTH  (IDX_W),
      .DEPTH  (MAX_VERTICES),
      .ADDR_W (IDX_W)
   ) u_remap_mem (
      .clock   (clock),
      .wr_en   (rm_we),
      .wr_addr (orig_cnt_ff[IDX_W-1:0]),
      .wr_data (res_idx_ff),
      .rd_addr (req_chan.corner_index),
      .rd_data (rm_rdata)
   );

   vdr_dist #(
      .COORD_BITS (COORD_BITS),
      .IDX_W      (IDX_W)
   ) u_dist (
      .clock    (clock),
      .reset    (reset),
      .flush    (flush),
      .in_vld   (iss_vld_ff),
      .in_tag   (iss_tag_ff),
      .in_last  (iss_last_ff),
      .ref_pt   (ref_pt_ff),
      .mem_pt   (pt_rdata),
      .eps      (eps_ff),
      .out_vld  (dist_vld),
      .out_hit  (dist_hit),
      .out_tag  (dist_tag),
      .out_last (dist_last)
   );

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign accept                = req_chan.valid && req_chan.ready;
   assign uniq_eff              = req_chan.first_of_mesh ? '0 : uniq_cnt_ff;
   assign orig_eff              = req_chan.first_of_mesh ? '0 : orig_cnt_ff;

   assign rsp_chan.valid        = rsp_vld_ff;
   assign rsp_chan.unique_index = rsp_idx_ff;
   assign rsp_chan.is_new       = rsp_new_ff;
   assign rsp_chan.status       = rsp_status_ff;

   // Sequencer next state
   always_comb begin
      state_in      = state_ff;
      uniq_cnt_in   = uniq_cnt_ff;
      orig_cnt_in   = orig_cnt_ff;
      eps_in        = csr_wr_en ? csr_wr_data : eps_ff;
      ref_pt_in     = ref_pt_ff;
      rd_idx_in     = rd_idx_ff;
      issue_done_in = issue_done_ff;
      iss_vld_in    = 1'b0;
      iss_tag_in    = rd_idx_ff;
      iss_last_in   = (CNT_W'(rd_idx_ff) == uniq_cnt_ff - CNT_W'(1));
      res_idx_in    = res_idx_ff;
      res_new_in    = res_new_ff;
      res_status_in = res_status_ff;
      rsp_vld_in    = rsp_vld_ff && !rsp_chan.ready;
      rsp_idx_in    = rsp_idx_ff;
      rsp_new_in    = rsp_new_ff;
      rsp_status_in = rsp_status_ff;
      pt_we         = 1'b0;
      rm_we         = 1'b0;
      flush         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               uniq_cnt_in   = uniq_eff;
               orig_cnt_in   = orig_eff;
               ref_pt_in     = {req_chan.coord_z, req_chan.coord_y, req_chan.coord_x};
               rd_idx_in     = '0;
               issue_done_in = 1'b0;
               res_idx_in    = '0;
               res_new_in    = 1'b0;
               res_status_in = STATUS_OK;
               if (req_chan.command == CMD_LOOKUP) begin
                  if (CNT_W'(req_chan.corner_index) < orig_eff) begin
                     state_in = ST_LOOKUP;
                  end else begin
                     res_status_in = STATUS_UNLOADED;
                     state_in      = ST_DONE;
                  end
               end else if (orig_eff == CNT_W'(MAX_VERTICES)) begin
                  res_status_in = STATUS_FULL;
                  state_in      = ST_DONE;
               end else if (uniq_eff == '0) begin
                  res_new_in = 1'b1;
                  state_in   = ST_COMMIT;
               end else begin
                  state_in = ST_SEARCH;
               end
            end
         end

         ST_SEARCH: begin
            // Issue one stored point per cycle up to the last one
            if (!issue_done_ff) begin
               iss_vld_in = 1'b1;
               if (iss_last_in) begin
                  issue_done_in = 1'b1;
               end else begin
                  rd_idx_in = rd_idx_ff + IDX_W'(1);
               end
            end
            // Stop at the first match or after the last compare
            if (dist_vld && (dist_hit || dist_last)) begin
               flush      = 1'b1;
               iss_vld_in = 1'b0;
               state_in   = ST_COMMIT;
               if (dist_hit) begin
                  res_idx_in = dist_tag;
                  res_new_in = 1'b0;
               end else begin
                  res_idx_in = uniq_cnt_ff[IDX_W-1:0];
                  res_new_in = 1'b1;
               end
            end
         end

         ST_LOOKUP: begin
            res_idx_in = rm_rdata;
            state_in   = ST_DONE;
         end

         ST_COMMIT: begin
            // Record the remap entry and append the point if it is new
            rm_we       = 1'b1;
            orig_cnt_in = orig_cnt_ff + CNT_W'(1);
            if (res_new_ff) begin
               pt_we       = 1'b1;
               uniq_cnt_in = uniq_cnt_ff + CNT_W'(1);
            end
            state_in = ST_DONE;
         end

         ST_DONE: begin
            // Retire into the output register once it is free
            if (!rsp_vld_ff || rsp_chan.ready) begin
               rsp_vld_in    = 1'b1;
               rsp_idx_in    = res_idx_ff;
               rsp_new_in    = res_new_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         uniq_cnt_ff   <= '0;
         orig_cnt_ff   <= '0;
         eps_ff        <= '0;
         issue_done_ff <= 1'b0;
         iss_vld_ff    <= 1'b0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         uniq_cnt_ff   <= uniq_cnt_in;
         orig_cnt_ff   <= orig_cnt_in;
         eps_ff        <= eps_in;
         issue_done_ff <= issue_done_in;
         iss_vld_ff    <= iss_vld_in;
         rsp_vld_ff    <= rsp_vld_in;
      end
      ref_pt_ff     <= ref_pt_in;
      rd_idx_ff     <= rd_idx_in;
      iss_tag_ff    <= iss_tag_in;
      iss_last_ff   <= iss_last_in;
      res_idx_ff    <= res_idx_in;
      res_new_ff    <= res_new_in;
      res_status_ff <= res_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_new_ff    <= rsp_new_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Unique points never outnumber original vertices
   assert property (@(posedge clock) disable iff (reset)
      uniq_cnt_ff <= orig_cnt_ff)
      else $error("unique count above original count");

   // Original count never passes the table depth
   assert property (@(posedge clock) disable iff (reset)
      orig_cnt_ff <= CNT_W'(MAX_VERTICES))
      else $error("original count beyond table depth");

   // A compare result during a search always names a stored point
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH && dist_vld) |-> (CNT_W'(dist_tag) < uniq_cnt_ff))
      else $error("distance result for an unstored entry");

   // Appending a point grows the unique count by one
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT && res_new_ff)
         |=> (uniq_cnt_ff == $past(uniq_cnt_ff) + CNT_W'(1)))
      else $error("append did not advance unique count");

   // A finished request waits while the output register is stalled
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_vld_ff && !rsp_chan.ready) |=> (state_ff == ST_DONE))
      else $error("response overwritten while stalled");

endmodule

`default_nettype wire

// ----- tb/vertex_dedup_remap_tb.sv -----
// Self-checking testbench for vertex_dedup_remap: vertex welding and index remap.
// Depends on vdr_pkg and the vdr_req_if / vdr_rsp_if channel interfaces.
`default_nettype none

module vertex_dedup_remap_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import vdr_pkg::*;

   localparam int MAX_V       = 1024;
   localparam int QUIET_LIMIT = 4000;
   localparam int LONG_HOLD   = 300;
   localparam int PHASE_REQS  = 72;
   localparam logic [EPS_W-1:0] EPS_MAX = 52'hF_FFFF_FFFF_FFFF;

   typedef struct packed {
      command_type command;
      logic        first_of_mesh;
      logic [23:0] coord_x;
      logic [23:0] coord_y;
      logic [23:0] coord_z;
      logic [9:0]  corner_index;
   } vertex_req_type;

   typedef struct packed {
      logic [9:0] unique_index;
      logic       is_new;
      status_type status;
   } weld_rsp_type;

   typedef struct packed {
      logic [23:0] x;
      logic [23:0] y;
      logic [23:0] z;
   } point_type;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [EPS_W-1:0] csr_wr_data;

   vdr_req_if #(.COORD_BITS(24), .IDX_W(10)) req_chan ();
   vdr_rsp_if #(.IDX_W(10))                  rsp_chan ();

   vertex_dedup_remap #(
      .MAX_VERTICES (MAX_V),
      .COORD_BITS   (24)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Welding state of the predictor
   int               kept_x [MAX_V];
   int               kept_y [MAX_V];
   int               kept_z [MAX_V];
   int unsigned      remap_of [MAX_V];
   int unsigned      kept_count;
   int unsigned      orig_count;
   logic [EPS_W-1:0] weld_eps;

   // Request and result stores
   vertex_req_type pending_reqs [$];
   weld_rsp_type   expected_welds [$];
   vertex_req_type in_flight;
   weld_rsp_type   want;
   int             error_count;

   // Stimulus-side view of the current mesh
   point_type mesh_pts [$];
   int        mesh_adds;

   // Flow control
   bit idle_on;
   bit hold_armed;
   bit hold_done;
   int send_gap;
   int rsp_stall_left;
   int hold_left;
   int quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Work out the response of one request and advance the welding state
   function automatic weld_rsp_type weld_vertex(vertex_req_type it);
      weld_rsp_type r;
      int           sx, sy, sz;
      longint       dx, dy, dz;
      logic [63:0]  sq_len;
      int unsigned  j, hit;
      bit           found;
      r = '{unique_index: '0, is_new: 1'b0, status: STATUS_OK};
      if (it.first_of_mesh) begin
         kept_count = 0;
         orig_count = 0;
      end
      if (it.command == CMD_ADD) begin
         if (orig_count >= MAX_V) begin
            r.status = STATUS_FULL;
         end else begin
            sx = {{8{it.coord_x[23]}}, it.coord_x};
            sy = {{8{it.coord_y[23]}}, it.coord_y};
            sz = {{8{it.coord_z[23]}}, it.coord_z};
            found = 1'b0;
            hit = kept_count;
            // Search kept points in order; first one strictly inside threshold wins
            for (j = 0; j < kept_count && !found; j++) begin
               dx = longint'(sx) - longint'(kept_x[j]);
               dy = longint'(sy) - longint'(kept_y[j]);
               dz = longint'(sz) - longint'(kept_z[j]);
               sq_len = dx * dx + dy * dy + dz * dz;
               if (sq_len < {12'd0, weld_eps}) begin
                  found = 1'b1;
                  hit = j;
               end
            end
            if (!found) begin
               kept_x[hit] = sx;
               kept_y[hit] = sy;
               kept_z[hit] = sz;
               kept_count++;
               r.is_new = 1'b1;
            end
            remap_of[orig_count] = hit;
            orig_count++;
            r.unique_index = hit[9:0];
         end
      end else begin
         if (it.corner_index < orig_count)
            r.unique_index = remap_of[it.corner_index][9:0];
         else
            r.status = STATUS_UNLOADED;
      end
      return r;
   endfunction

   // Request driver: offer queued requests, predict each one as it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            expected_welds.insert(expected_welds.size(), weld_vertex(in_flight));
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap == 0 && idle_on && $urandom_range(0, 5) == 0)
               send_gap = $urandom_range(1, 5);
            if (send_gap > 0) begin
               send_gap--;
               req_chan.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               in_flight = pending_reqs.pop_front();
               req_chan.valid         <= 1'b1;
               req_chan.command       <= in_flight.command;
               req_chan.first_of_mesh <= in_flight.first_of_mesh;
               req_chan.coord_x       <= in_flight.coord_x;
               req_chan.coord_y       <= in_flight.coord_y;
               req_chan.coord_z       <= in_flight.coord_z;
               req_chan.corner_index  <= in_flight.corner_index;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Response ready: random stalls, plus one long hold to back the block up
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall_left = 0;
         hold_left = 0;
         hold_done = 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else if (hold_armed && !hold_done) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD - 1;
         rsp_chan.ready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_chan.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_stall_left = $urandom_range(0, 4);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Response monitor: compare each response with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_welds.size() == 0) begin
            $display("%0t: response with none pending: index %0d new %0b status %0d",
                     $time, rsp_chan.unique_index, rsp_chan.is_new, rsp_chan.status);
            error_count++;
         end else begin
            want = expected_welds.pop_front();
            if (rsp_chan.unique_index !== want.unique_index) begin
               $display("%0t: unique_index expected %0d actual %0d",
                        $time, want.unique_index, rsp_chan.unique_index);
               error_count++;
            end
            if (rsp_chan.is_new !== want.is_new) begin
               $display("%0t: is_new expected %0b actual %0b",
                        $time, want.is_new, rsp_chan.is_new);
               error_count++;
            end
            if (rsp_chan.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_chan.status);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
      begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   task automatic queue_add(bit fom, logic [23:0] x, logic [23:0] y, logic [23:0] z);
      vertex_req_type item;
      point_type      pt;
      item.command       = CMD_ADD;
      item.first_of_mesh = fom;
      item.coord_x       = x;
      item.coord_y       = y;
      item.coord_z       = z;
      item.corner_index  = 10'($urandom);
      if (fom) begin
         mesh_pts.delete();
         mesh_adds = 0;
      end
      pt = '{x: x, y: y, z: z};
      mesh_pts.insert(mesh_pts.size(), pt);
      mesh_adds++;
      pending_reqs.insert(pending_reqs.size(), item);
   endtask

   task automatic queue_lookup(bit fom, logic [9:0] corner);
      vertex_req_type item;
      item.command       = CMD_LOOKUP;
      item.first_of_mesh = fom;
      item.coord_x       = 24'($urandom);
      item.coord_y       = 24'($urandom);
      item.coord_z       = 24'($urandom);
      item.corner_index  = corner;
      if (fom) begin
         mesh_pts.delete();
         mesh_adds = 0;
      end
      pending_reqs.insert(pending_reqs.size(), item);
   endtask

   // Hold until every queued request is taken and every response is back
   task automatic wait_idle();
      do
         @(negedge clock);
      while (pending_reqs.size() != 0 || req_chan.valid || expected_welds.size() != 0);
   endtask

   task automatic write_threshold(logic [EPS_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      weld_eps = value;
      @(negedge clock);
   endtask

   // Random coordinate, now and then pinned to an extreme or to zero
   function automatic logic [23:0] pick_coord();
      case ($urandom_range(0, 29))
         0:       return 24'h800000;
         1:       return 24'h7FFFFF;
         2:       return 24'h000000;
         default: return 24'($urandom);
      endcase
   endfunction

   // Shift a coordinate by a small random amount of varying scale
   function automatic logic [23:0] nudge(logic [23:0] c);
      int s;
      case ($urandom_range(0, 5))
         0:       s = 0;
         1:       s = 1;
         2:       s = 4;
         3:       s = 40;
         4:       s = 1000;
         default: s = 70000;
      endcase
      return c + 24'($urandom_range(0, 2 * s) - s);
   endfunction

   // One phase of random meshes: adds near earlier points, fresh adds, lookups
   task automatic build_random_phase(int n_reqs);
      int        k, mesh_left, choice;
      bit        fom;
      point_type base;
      mesh_left = 0;
      for (k = 0; k < n_reqs; k++) begin
         fom = 1'b0;
         if (mesh_left == 0) begin
            fom = 1'b1;
            mesh_left = $urandom_range(1, 40);
         end else if ($urandom_range(0, 49) == 0) begin
            fom = 1'b1;
         end
         mesh_left--;
         choice = $urandom_range(0, 99);
         if (choice < 55) begin
            if (!fom && mesh_pts.size() > 0 && $urandom_range(0, 9) < 6) begin
               base = mesh_pts[$urandom_range(0, mesh_pts.size() - 1)];
               queue_add(fom, nudge(base.x), nudge(base.y), nudge(base.z));
            end else begin
               queue_add(fom, pick_coord(), pick_coord(), pick_coord());
            end
         end else if (choice < 90 && !fom && mesh_adds > 0) begin
            queue_lookup(fom, 10'($urandom_range(0, mesh_adds - 1)));
         end else begin
            queue_lookup(fom, 10'($urandom));
         end
      end
   endtask

   initial begin
      logic [EPS_W-1:0] eps_plan [8];
      int               p, k;
      reset                  = 1'b1;
      csr_wr_en              = 1'b0;
      csr_wr_data            = '0;
      req_chan.valid         = 1'b0;
      req_chan.command       = CMD_ADD;
      req_chan.first_of_mesh = 1'b0;
      req_chan.coord_x       = '0;
      req_chan.coord_y       = '0;
      req_chan.coord_z       = '0;
      req_chan.corner_index  = '0;
      rsp_chan.ready         = 1'b0;
      error_count            = 0;
      kept_count             = 0;
      orig_count             = 0;
      weld_eps               = '0;
      mesh_adds              = 0;
      idle_on                = 1'b1;
      hold_armed             = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Zero threshold from reset: lookup on empty tables, nothing ever welds
      queue_lookup(1'b0, 10'd0);
      queue_add(1'b1, 24'h000000, 24'h000000, 24'h000000);
      queue_add(1'b0, 24'h000000, 24'h000000, 24'h000000);
      queue_add(1'b0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
      queue_add(1'b0, 24'h800000, 24'h800000, 24'h800000);
      queue_lookup(1'b0, 10'd0);
      queue_lookup(1'b0, 10'd3);
      queue_lookup(1'b0, 10'd4);
      queue_lookup(1'b0, 10'd1023);
      wait_idle();

      // Threshold of two: distance one welds, distance two does not
      write_threshold(52'd2);
      queue_add(1'b1, 24'h000000, 24'h000000, 24'h000000);
      queue_add(1'b0, 24'h000001, 24'h000000, 24'h000000);
      queue_add(1'b0, 24'h000001, 24'h000001, 24'h000000);
      queue_add(1'b0, 24'h000001, 24'h000001, 24'h000001);
      queue_lookup(1'b0, 10'd3);
      queue_lookup(1'b1, 10'd0);
      queue_add(1'b0, 24'h7FFFFF, 24'h000000, 24'h800000);
      wait_idle();

      // Largest threshold: opposite corners of the range still weld
      write_threshold(EPS_MAX);
      queue_add(1'b1, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
      queue_add(1'b0, 24'h800000, 24'h800000, 24'h800000);
      queue_add(1'b0, 24'h000000, 24'h800000, 24'h7FFFFF);
      queue_lookup(1'b0, 10'd2);
      queue_lookup(1'b0, 10'd1023);
      wait_idle();

      // Random meshes over a spread of thresholds
      eps_plan = '{52'd1, 52'd50, 52'd4096, 52'h10_0000, 52'h4000_0000,
                   52'h100_0000_0000, 52'd0, 52'd0};
      eps_plan[6] = EPS_W'({$urandom, $urandom});
      for (p = 0; p < 8; p++) begin
         write_threshold(eps_plan[p]);
         build_random_phase(PHASE_REQS);
         if (p == 1)
            hold_armed = 1'b1;
         wait_idle();
      end

      // Fill the table with distinct points, then run into the full case
      idle_on = 1'b0;
      write_threshold('0);
      queue_add(1'b1, pick_coord(), pick_coord(), pick_coord());
      for (k = 1; k < MAX_V; k++)
         queue_add(1'b0, pick_coord(), pick_coord(), pick_coord());
      queue_add(1'b0, pick_coord(), pick_coord(), pick_coord());
      queue_add(1'b0, 24'h800000, 24'h7FFFFF, 24'h000000);
      queue_lookup(1'b0, 10'd1023);
      queue_lookup(1'b0, 10'd0);
      for (k = 0; k < 8; k++)
         queue_lookup(1'b0, 10'($urandom));
      queue_add(1'b1, pick_coord(), pick_coord(), pick_coord());
      queue_lookup(1'b0, 10'd0);
      queue_lookup(1'b0, 10'd1);
      wait_idle();

      // Let any stray response show up before the verdict
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire

// ----- sim.f -----
design/vdr_pkg.sv
design/vdr_if.sv
design/vdr_mem.sv
design/vdr_dist.sv
design/vertex_dedup_remap.sv
tb/vertex_dedup_remap_tb.sv
